>>> src/tcs_pkg.sv
// Shared constants and types for the text console with scroll-back.
// No dependencies; imported by every module of the block except tcs_ram.
package tcs_pkg;

    localparam int unsigned DEF_COLUMNS      = 80;
    localparam int unsigned DEF_ROWS         = 25;
    localparam int unsigned DEF_HISTORY_ROWS = 100;

    localparam logic [15:0] BLANK_CELL = 16'h0720;

    localparam logic [2:0] CMD_PUT       = 3'd0;
    localparam logic [2:0] CMD_NEWLINE   = 3'd1;
    localparam logic [2:0] CMD_BACKSPACE = 3'd2;
    localparam logic [2:0] CMD_CLEAR     = 3'd3;
    localparam logic [2:0] CMD_VIEW_UP   = 3'd4;
    localparam logic [2:0] CMD_VIEW_DOWN = 3'd5;
    localparam logic [2:0] CMD_READ      = 3'd6;

    typedef enum logic [1:0] {
        MEM_SCREEN = 2'd0,
        MEM_HIST   = 2'd1,
        MEM_SAVED  = 2'd2
    } t_mem_sel;

endpackage

>>> src/tcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the screen, history and saved stores.
module tcs_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> src/text_console_with_scrollback_unit.sv
// Top level of the text console: command sequencer with one copy/fill engine.
// Depends on tcs_pkg and tcs_ram.
//
//  channel  | handshake               | fields
//  ---------+-------------------------+------------------------------------------------
//  command  | start / busy            | i_cmd, i_char_code, i_color, i_cell_index
//  result   | o_done (one-cycle pulse)| o_cursor_x, o_cursor_y, o_read_char, o_read_attr,
//           |                         | o_history_count, o_view_lines_back
//
// A scroll copies the top row into history and shifts the screen up a row in the
// single copy engine (one read and one write per cell), then blanks the last row.
// Clear fills the whole screen with blanks. View up and down blank the screen and
// copy in each history row shown; view up first saves the live screen when leaving
// it, and view down back to the live screen restores it from the saved store instead.
// After reset a clearing pass blanks the screen; busy is high.
// The receiver cannot stall: each result is shown for one cycle only.
module text_console_with_scrollback_unit
    import tcs_pkg::*;
#(
    parameter int unsigned COLUMNS      = DEF_COLUMNS,
    parameter int unsigned ROWS         = DEF_ROWS,
    parameter int unsigned HISTORY_ROWS = DEF_HISTORY_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color,
    input  logic [10:0] i_cell_index,
    output logic        o_done,
    output logic [6:0]  o_cursor_x,
    output logic [4:0]  o_cursor_y,
    output logic [7:0]  o_read_char,
    output logic [7:0]  o_read_attr,
    output logic [6:0]  o_history_count,
    output logic [6:0]  o_view_lines_back
);

    localparam int unsigned SCREEN = COLUMNS * ROWS;
    localparam int unsigned HCELLS = HISTORY_ROWS * COLUMNS;
    localparam int unsigned SA     = $clog2(SCREEN);
    localparam int unsigned HA     = $clog2(HCELLS);
    localparam int unsigned AW     = (SA > HA) ? SA : HA;
    localparam int unsigned CW     = $clog2(SCREEN + 1);
    localparam int unsigned CELLW  = $clog2(SCREEN + COLUMNS + 1);
    localparam int unsigned XW     = $clog2(COLUMNS);
    localparam int unsigned YW     = $clog2(ROWS + 2);
    localparam int unsigned HCW    = $clog2(HISTORY_ROWS + 1);
    localparam int unsigned HRW    = (HISTORY_ROWS > 1) ? $clog2(HISTORY_ROWS) : 1;
    localparam int unsigned OW     = $clog2(HISTORY_ROWS + 2);
    localparam int unsigned SW     = HCW + 1;

    typedef enum logic [15:0] {
        S_IDLE       = 16'h0001,
        S_FILL       = 16'h0002,
        S_COPY_RD    = 16'h0004,
        S_COPY_WR    = 16'h0008,
        S_WR         = 16'h0010,
        S_READ       = 16'h0020,
        S_READ_CAP   = 16'h0040,
        S_PUSH       = 16'h0080,
        S_PUSH_GO    = 16'h0100,
        S_SHIFT      = 16'h0200,
        S_BLANK      = 16'h0400,
        S_SCROLL_END = 16'h0800,
        S_DRAW       = 16'h1000,
        S_DRAW_INIT  = 16'h2000,
        S_DRAW_ROW   = 16'h4000,
        S_DONE       = 16'h8000
    } t_state;

    t_state         r_state, n_state, r_ret, n_ret, r_after, n_after;
    logic [AW-1:0]  r_src, n_src, r_dst, n_dst;
    logic [CW-1:0]  r_cnt, n_cnt;
    t_mem_sel       r_src_sel, n_src_sel, r_dst_sel, n_dst_sel;
    logic [CELLW-1:0] r_cell, n_cell;
    logic [XW-1:0]  r_x, n_x;
    logic [YW-1:0]  r_y, n_y;
    logic [HCW-1:0] r_hist, n_hist;
    logic [HRW-1:0] r_head, n_head, r_row, n_row;
    logic [OW-1:0]  r_off, n_off;
    logic [YW-1:0]  r_line, n_line, r_lines, n_lines;
    logic [15:0]    r_wdata, n_wdata;
    logic           r_is_put, n_is_put;
    logic [7:0]     r_rd_char, n_rd_char, r_rd_attr, n_rd_attr;

    logic           scr_we, hist_we, sav_we;
    logic [SA-1:0]  scr_waddr;
    logic [15:0]    scr_wdata;
    logic [15:0]    scr_rdata, hist_rdata, sav_rdata, src_data;

    logic [SW-1:0]  sum_w;
    logic [OW-1:0]  off_c;

    tcs_ram #(.WIDTH(16), .DEPTH(SCREEN)) u_screen (
        .i_clk   (i_clk),
        .i_we    (scr_we),
        .i_waddr (scr_waddr),
        .i_wdata (scr_wdata),
        .i_raddr (r_src[SA-1:0]),
        .o_rdata (scr_rdata)
    );

    tcs_ram #(.WIDTH(16), .DEPTH(HCELLS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (hist_we),
        .i_waddr (r_dst[HA-1:0]),
        .i_wdata (src_data),
        .i_raddr (r_src[HA-1:0]),
        .o_rdata (hist_rdata)
    );

    tcs_ram #(.WIDTH(16), .DEPTH(SCREEN)) u_saved (
        .i_clk   (i_clk),
        .i_we    (sav_we),
        .i_waddr (r_dst[SA-1:0]),
        .i_wdata (src_data),
        .i_raddr (r_src[SA-1:0]),
        .o_rdata (sav_rdata)
    );

    always_comb begin
        case (r_src_sel)
            MEM_HIST:  src_data = hist_rdata;
            MEM_SAVED: src_data = sav_rdata;
            default:   src_data = scr_rdata;
        endcase
    end

    // Write ports: screen fill, copy into any store, or single-cell write at the cursor
    always_comb begin
        scr_we    = 1'b0;
        scr_waddr = r_dst[SA-1:0];
        scr_wdata = BLANK_CELL;
        hist_we   = 1'b0;
        sav_we    = 1'b0;
        case (r_state)
            S_FILL: scr_we = 1'b1;
            S_COPY_WR: begin
                scr_we    = (r_dst_sel == MEM_SCREEN);
                hist_we   = (r_dst_sel == MEM_HIST);
                sav_we    = (r_dst_sel == MEM_SAVED);
                scr_wdata = src_data;
            end
            S_WR: begin
                scr_we    = 1'b1;
                scr_waddr = r_cell[SA-1:0];
                scr_wdata = r_wdata;
            end
            default: ;
        endcase
    end

    // Clamp the view offset to the history fill and locate the first shown row
    assign off_c = (r_off > OW'(r_hist)) ? OW'(r_hist) : r_off;
    always_comb begin
        sum_w = SW'(r_head) + SW'(r_hist) - SW'(off_c);
        if (sum_w >= SW'(HISTORY_ROWS)) begin
            sum_w = sum_w - SW'(HISTORY_ROWS);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_after   = r_after;
        n_src     = r_src;
        n_dst     = r_dst;
        n_cnt     = r_cnt;
        n_src_sel = r_src_sel;
        n_dst_sel = r_dst_sel;
        n_cell    = r_cell;
        n_x       = r_x;
        n_y       = r_y;
        n_hist    = r_hist;
        n_head    = r_head;
        n_row     = r_row;
        n_off     = r_off;
        n_line    = r_line;
        n_lines   = r_lines;
        n_wdata   = r_wdata;
        n_is_put  = r_is_put;
        n_rd_char = r_rd_char;
        n_rd_attr = r_rd_attr;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rd_char = '0;
                    n_rd_attr = '0;
                    n_state   = S_DONE;
                    case (i_cmd)
                        CMD_PUT: begin
                            n_wdata  = {i_color, i_char_code};
                            n_is_put = 1'b1;
                            if (r_y == YW'(ROWS)) begin
                                n_after = S_WR;
                                n_state = S_PUSH;
                            end else begin
                                n_state = S_WR;
                            end
                        end
                        CMD_NEWLINE: begin
                            n_cell = r_cell + CELLW'(COLUMNS) - CELLW'(r_x);
                            n_x    = '0;
                            n_y    = r_y + 1'b1;
                            if (r_y + 1'b1 >= YW'(ROWS)) begin
                                n_after = S_DONE;
                                n_state = S_PUSH;
                            end
                        end
                        CMD_BACKSPACE: begin
                            if (r_cell != '0) begin
                                n_cell = r_cell - 1'b1;
                                if (r_x == '0) begin
                                    n_x = XW'(COLUMNS - 1);
                                    n_y = r_y - 1'b1;
                                end else begin
                                    n_x = r_x - 1'b1;
                                end
                                n_wdata  = BLANK_CELL;
                                n_is_put = 1'b0;
                                n_state  = S_WR;
                            end
                        end
                        CMD_CLEAR: begin
                            n_cell  = '0;
                            n_x     = '0;
                            n_y     = '0;
                            n_dst   = '0;
                            n_cnt   = CW'(SCREEN);
                            n_ret   = S_DONE;
                            n_state = S_FILL;
                        end
                        CMD_VIEW_UP: begin
                            if (r_hist != '0) begin
                                n_off = r_off + 1'b1;
                                if (r_off == '0) begin
                                    n_src     = '0;
                                    n_dst     = '0;
                                    n_cnt     = CW'(SCREEN);
                                    n_src_sel = MEM_SCREEN;
                                    n_dst_sel = MEM_SAVED;
                                    n_ret     = S_DRAW;
                                    n_state   = S_COPY_RD;
                                end else begin
                                    n_state = S_DRAW;
                                end
                            end
                        end
                        CMD_VIEW_DOWN: begin
                            if (r_off != '0) begin
                                n_off = r_off - 1'b1;
                                if (r_off == OW'(1)) begin
                                    n_src     = '0;
                                    n_dst     = '0;
                                    n_cnt     = CW'(SCREEN);
                                    n_src_sel = MEM_SAVED;
                                    n_dst_sel = MEM_SCREEN;
                                    n_ret     = S_DONE;
                                    n_state   = S_COPY_RD;
                                end else begin
                                    n_state = S_DRAW;
                                end
                            end
                        end
                        CMD_READ: begin
                            if (32'(i_cell_index) < 32'(SCREEN)) begin
                                n_src     = AW'(i_cell_index);
                                n_src_sel = MEM_SCREEN;
                                n_state   = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_FILL: begin
                n_dst = r_dst + 1'b1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = r_ret;
                end
            end
            S_COPY_RD: n_state = S_COPY_WR;
            S_COPY_WR: begin
                n_src = r_src + 1'b1;
                n_dst = r_dst + 1'b1;
                n_cnt = r_cnt - 1'b1;
                n_state = (r_cnt == CW'(1)) ? r_ret : S_COPY_RD;
            end
            S_WR: begin
                if (r_is_put) begin
                    n_cell = r_cell + 1'b1;
                    if (r_x == XW'(COLUMNS - 1)) begin
                        n_x = '0;
                        n_y = r_y + 1'b1;
                    end else begin
                        n_x = r_x + 1'b1;
                    end
                end
                n_state = S_DONE;
            end
            S_READ: n_state = S_READ_CAP;
            S_READ_CAP: begin
                n_rd_char = scr_rdata[7:0];
                n_rd_attr = scr_rdata[15:8];
                n_state   = S_DONE;
            end
            // Pick the history row for the outgoing top line; drop the oldest when full
            S_PUSH: begin
                if (r_hist == HCW'(HISTORY_ROWS)) begin
                    n_row  = r_head;
                    n_head = (r_head == HRW'(HISTORY_ROWS - 1)) ? '0 : r_head + 1'b1;
                end else begin
                    n_row  = (SW'(r_head) + SW'(r_hist) >= SW'(HISTORY_ROWS))
                           ? HRW'(SW'(r_head) + SW'(r_hist) - SW'(HISTORY_ROWS))
                           : HRW'(SW'(r_head) + SW'(r_hist));
                    n_hist = r_hist + 1'b1;
                end
                n_state = S_PUSH_GO;
            end
            S_PUSH_GO: begin
                n_dst     = AW'(AW'(r_row) * AW'(COLUMNS));
                n_src     = '0;
                n_cnt     = CW'(COLUMNS);
                n_src_sel = MEM_SCREEN;
                n_dst_sel = MEM_HIST;
                n_ret     = S_SHIFT;
                n_state   = S_COPY_RD;
            end
            S_SHIFT: begin
                n_src     = AW'(COLUMNS);
                n_dst     = '0;
                n_cnt     = CW'(SCREEN - COLUMNS);
                n_src_sel = MEM_SCREEN;
                n_dst_sel = MEM_SCREEN;
                n_ret     = S_BLANK;
                n_state   = S_COPY_RD;
            end
            S_BLANK: begin
                n_dst   = AW'(SCREEN - COLUMNS);
                n_cnt   = CW'(COLUMNS);
                n_ret   = S_SCROLL_END;
                n_state = S_FILL;
            end
            S_SCROLL_END: begin
                n_cell  = r_cell - CELLW'(COLUMNS);
                n_y     = r_y - 1'b1;
                n_off   = '0;
                n_state = r_after;
            end
            S_DRAW: begin
                n_dst   = '0;
                n_cnt   = CW'(SCREEN);
                n_ret   = S_DRAW_INIT;
                n_state = S_FILL;
            end
            S_DRAW_INIT: begin
                n_off   = off_c;
                n_row   = HRW'(sum_w);
                n_lines = (off_c < OW'(ROWS)) ? YW'(off_c) : YW'(ROWS);
                n_line  = '0;
                n_dst   = '0;
                n_state = S_DRAW_ROW;
            end
            // Copy one history row per pass; destination address runs on
            S_DRAW_ROW: begin
                if (r_line == r_lines) begin
                    n_state = S_DONE;
                end else begin
                    n_src     = AW'(AW'(r_row) * AW'(COLUMNS));
                    n_cnt     = CW'(COLUMNS);
                    n_src_sel = MEM_HIST;
                    n_dst_sel = MEM_SCREEN;
                    n_ret     = S_DRAW_ROW;
                    n_line    = r_line + 1'b1;
                    n_row     = (r_row == HRW'(HISTORY_ROWS - 1)) ? '0 : r_row + 1'b1;
                    n_state   = S_COPY_RD;
                end
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_FILL;
            r_ret    <= S_IDLE;
            r_after  <= S_DONE;
            r_dst    <= '0;
            r_src    <= '0;
            r_cnt    <= CW'(SCREEN);
            r_cell   <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_hist   <= '0;
            r_head   <= '0;
            r_off    <= '0;
            r_line   <= '0;
            r_lines  <= '0;
            r_src_sel <= MEM_SCREEN;
            r_dst_sel <= MEM_SCREEN;
            r_rd_char <= '0;
            r_rd_attr <= '0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_after   <= n_after;
            r_dst     <= n_dst;
            r_src     <= n_src;
            r_cnt     <= n_cnt;
            r_cell    <= n_cell;
            r_x       <= n_x;
            r_y       <= n_y;
            r_hist    <= n_hist;
            r_head    <= n_head;
            r_off     <= n_off;
            r_line    <= n_line;
            r_lines   <= n_lines;
            r_src_sel <= n_src_sel;
            r_dst_sel <= n_dst_sel;
            r_rd_char <= n_rd_char;
            r_rd_attr <= n_rd_attr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row    <= n_row;
        r_wdata  <= n_wdata;
        r_is_put <= n_is_put;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_done            = (r_state == S_DONE);
    assign o_cursor_x        = 7'(r_x);
    assign o_cursor_y        = 5'(r_y);
    assign o_read_char       = r_rd_char;
    assign o_read_attr       = r_rd_attr;
    assign o_history_count   = 7'(r_hist);
    assign o_view_lines_back = 7'(r_off);

endmodule

>>> src/tcs_checker.sv
// Port-level checks for the text console, bound to the top level.
// Depends on tcs_pkg for default geometry.
module tcs_props
    import tcs_pkg::*;
#(
    parameter int unsigned COLUMNS = DEF_COLUMNS
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_done,
    input logic [6:0] o_cursor_x,
    input logic [6:0] o_history_count,
    input logic [6:0] o_view_lines_back
);

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done && !busy)
        else $error("result strobe longer than one cycle");

    a_view_le_hist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_view_lines_back <= o_history_count)
        else $error("view offset beyond history");

    a_cursor_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> 32'(o_cursor_x) < COLUMNS)
        else $error("cursor column out of range");

endmodule

bind text_console_with_scrollback_unit tcs_props #(.COLUMNS(COLUMNS)) u_tcs_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .start             (start),
    .busy              (busy),
    .o_done            (o_done),
    .o_cursor_x        (o_cursor_x),
    .o_history_count   (o_history_count),
    .o_view_lines_back (o_view_lines_back)
);

>>> test/tcs_checker.sv
// Checker for the text console: predicts each command's result and compares
// it with the block's output. Depends on tcs_pkg only.
module tcs_checker
    import tcs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [2:0]  i_cmd,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_color,
    input  logic [10:0] i_cell_index,
    input  logic        o_done,
    input  logic [6:0]  o_cursor_x,
    input  logic [4:0]  o_cursor_y,
    input  logic [7:0]  o_read_char,
    input  logic [7:0]  o_read_attr,
    input  logic [6:0]  o_history_count,
    input  logic [6:0]  o_view_lines_back,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS  = DEF_COLUMNS;
    localparam int LINES = DEF_ROWS;
    localparam int HROWS = DEF_HISTORY_ROWS;
    localparam int CELLS = COLS * LINES;

    typedef struct {
        logic [6:0] cx;
        logic [4:0] cy;
        logic [7:0] rchar;
        logic [7:0] rattr;
        logic [6:0] hcount;
        logic [6:0] vback;
    } t_status;

    logic [15:0] screen_cells [CELLS];
    logic [15:0] history_cells [HROWS*COLS];
    logic [15:0] saved_cells [CELLS];
    int unsigned cursor, hist_lines, view_back;
    t_status status_q[$];

    task automatic blank_all();
        for (int i = 0; i < CELLS; i++) screen_cells[i] = BLANK_CELL;
    endtask

    task automatic scroll_one_line();
        if (hist_lines >= HROWS) begin
            for (int i = 0; i < (HROWS-1)*COLS; i++) history_cells[i] = history_cells[i+COLS];
            hist_lines = HROWS - 1;
        end
        for (int i = 0; i < COLS; i++) history_cells[hist_lines*COLS + i] = screen_cells[i];
        hist_lines++;
        for (int i = 0; i < (LINES-1)*COLS; i++) screen_cells[i] = screen_cells[i+COLS];
        for (int i = (LINES-1)*COLS; i < CELLS; i++) screen_cells[i] = BLANK_CELL;
        cursor = (cursor >= COLS) ? cursor - COLS : 0;
        view_back = 0;
    endtask

    task automatic show_history();
        int unsigned first, shown;
        blank_all();
        if (view_back > hist_lines) view_back = hist_lines;
        first = hist_lines - view_back;
        shown = (view_back < LINES) ? view_back : LINES;
        for (int l = 0; l < shown; l++)
            for (int c = 0; c < COLS; c++)
                screen_cells[l*COLS + c] = history_cells[(first+l)*COLS + c];
    endtask

    task automatic run_command(input logic [2:0] op, input logic [7:0] ch,
                               input logic [7:0] attr, input logic [10:0] idx,
                               output t_status st);
        st.rchar = '0;
        st.rattr = '0;
        case (op)
            CMD_PUT: begin
                if (cursor >= CELLS) scroll_one_line();
                if (cursor < CELLS) begin
                    screen_cells[cursor] = {attr, ch};
                    cursor++;
                end
            end
            CMD_NEWLINE: begin
                cursor += COLS - (cursor % COLS);
                if (cursor >= CELLS) scroll_one_line();
            end
            CMD_BACKSPACE: begin
                if (cursor >= 1) begin
                    cursor--;
                    if (cursor < CELLS) screen_cells[cursor] = BLANK_CELL;
                end
            end
            CMD_CLEAR: begin
                blank_all();
                cursor = 0;
            end
            CMD_VIEW_UP: begin
                if (hist_lines != 0) begin
                    if (view_back == 0) saved_cells = screen_cells;
                    view_back++;
                    show_history();
                end
            end
            CMD_VIEW_DOWN: begin
                if (view_back != 0) begin
                    view_back--;
                    if (view_back == 0) screen_cells = saved_cells;
                    else show_history();
                end
            end
            CMD_READ: begin
                if (idx < CELLS) {st.rattr, st.rchar} = screen_cells[idx];
            end
            default: ;
        endcase
        st.cx = 7'(cursor % COLS);
        st.cy = 5'(cursor / COLS);
        st.hcount = 7'(hist_lines);
        st.vback = 7'(view_back);
    endtask

    function automatic int field_err(string name, int expv, int actv);
        if (expv == actv) return 0;
        $display("%0t: %s expected %0d actual %0d", $realtime, name, expv, actv);
        return 1;
    endfunction

    initial begin
        o_fail_count = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        t_status want, got;
        int errs;
        if (!i_rst_n) begin
            blank_all();
            cursor = 0;
            hist_lines = 0;
            view_back = 0;
            status_q.delete();
        end else begin
            // compare before predicting: a transfer accepted now cannot finish now
            if (o_done) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result with no command outstanding", $realtime);
                    o_fail_count++;
                end else begin
                    want = status_q.pop_front();
                    errs = field_err("cursor_x", want.cx, o_cursor_x)
                         + field_err("cursor_y", want.cy, o_cursor_y)
                         + field_err("read_char", want.rchar, o_read_char)
                         + field_err("read_attr", want.rattr, o_read_attr)
                         + field_err("history_count", want.hcount, o_history_count)
                         + field_err("view_lines_back", want.vback, o_view_lines_back);
                    if (errs != 0) o_fail_count++;
                end
            end
            if (start && !busy) begin
                run_command(i_cmd, i_char_code, i_color, i_cell_index, got);
                status_q.push_back(got);
            end
        end
        o_outstanding = status_q.size();
    end
endmodule

>>> test/text_console_with_scrollback_unit_tb.sv
// Stimulus and verdict for the text console with scroll-back.
// Depends on tcs_pkg, text_console_with_scrollback_unit and tcs_checker.
module text_console_with_scrollback_unit_tb
    import tcs_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 60_000_000;
    localparam int RANDOM_ITEMS = 1240;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_cmd = CMD_READ;
    logic [7:0]  i_char_code = '0;
    logic [7:0]  i_color = '0;
    logic [10:0] i_cell_index = '0;
    logic        o_done;
    logic [6:0]  o_cursor_x, o_history_count, o_view_lines_back;
    logic [4:0]  o_cursor_y;
    logic [7:0]  o_read_char, o_read_attr;
    int          fail_count, outstanding;
    int          cycles = 0;

    text_console_with_scrollback_unit dut (.*);

    tcs_checker checker_i (.*, .o_fail_count(fail_count), .o_outstanding(outstanding));

    initial forever #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Hold start high until the transfer is taken, then maybe drop it for a gap.
    task automatic issue(input logic [2:0] op, input logic [7:0] ch,
                         input logic [7:0] attr, input logic [10:0] idx);
        int r, gap;
        start <= 1'b1;
        i_cmd <= op;
        i_char_code <= ch;
        i_color <= attr;
        i_cell_index <= idx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = $urandom_range(99);
        gap = (r < 65) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic issue_op(input logic [2:0] op);
        issue(op, 8'($urandom), 8'($urandom), 11'($urandom));
    endtask

    initial begin
        int r;
        logic [2:0] op;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        issue(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
        issue(CMD_VIEW_UP, 8'h00, 8'h00, 11'd0);
        issue(CMD_VIEW_DOWN, 8'h00, 8'h00, 11'd0);
        issue(CMD_PUT, 8'hFF, 8'hFF, 11'd0);
        issue(CMD_PUT, 8'h00, 8'h00, 11'd0);
        issue(CMD_READ, 8'h00, 8'h00, 11'd0);
        issue(CMD_READ, 8'h00, 8'h00, 11'd1999);
        issue(CMD_READ, 8'h00, 8'h00, 11'd2000);
        issue(CMD_READ, 8'hFF, 8'hFF, 11'd2047);
        issue(3'd7, 8'hFF, 8'hFF, 11'd2047);
        for (int i = 0; i < 26; i++) issue(CMD_NEWLINE, 8'h41, 8'h1E, 11'd0);
        repeat (3) issue(CMD_VIEW_UP, 8'h00, 8'h00, 11'd0);
        issue(CMD_PUT, 8'h5A, 8'h4F, 11'd0);
        issue(CMD_VIEW_DOWN, 8'h00, 8'h00, 11'd0);
        issue(CMD_NEWLINE, 8'h00, 8'h00, 11'd0);
        issue(CMD_VIEW_UP, 8'h00, 8'h00, 11'd0);
        repeat (3) issue(CMD_VIEW_DOWN, 8'h00, 8'h00, 11'd0);
        issue(CMD_READ, 8'h00, 8'h00, 11'd0);
        // fill the last row to park the cursor past the bottom
        for (int i = 0; i < 80; i++) issue(CMD_PUT, 8'(i), 8'h07, 11'd0);
        issue(CMD_NEWLINE, 8'h00, 8'h00, 11'd0);
        for (int i = 0; i < 80; i++) issue(CMD_PUT, 8'(i + 100), 8'h70, 11'd0);
        issue(CMD_BACKSPACE, 8'h00, 8'h00, 11'd0);
        issue(CMD_PUT, 8'h21, 8'h0C, 11'd0);
        issue(CMD_PUT, 8'h22, 8'h0C, 11'd0);
        issue(CMD_CLEAR, 8'h00, 8'h00, 11'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = $urandom_range(999);
            if (r < 20) begin
                // a full row of text without a line break
                for (int i = 0; i < 80; i++) issue_op(CMD_PUT);
                n += 79;
                continue;
            end
            op = (r < 420) ? CMD_PUT : (r < 500) ? CMD_NEWLINE : (r < 600) ? CMD_BACKSPACE :
                 (r < 630) ? CMD_CLEAR : (r < 645) ? CMD_VIEW_UP : (r < 660) ? CMD_VIEW_DOWN :
                 (r < 990) ? CMD_READ : 3'd7;
            if (op == CMD_READ)
                issue(op, 8'($urandom), 8'($urandom),
                      ($urandom_range(9) == 0) ? 11'($urandom_range(2000, 2047))
                                               : 11'($urandom_range(1999)));
            else
                issue_op(op);
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
